// ----- hdl/tmcr_pkg.sv -----
// Shared constants and types for the texture matrix crop recovery block.
`timescale 1ns / 1ps
`default_nettype none

package tmcr_pkg;

  // Default fixed-point and size widths.
  localparam int FRAC_BITS_DEF  = 16;
  localparam int SIZE_BITS_DEF  = 14;
  localparam int CODED_BITS_DEF = 16;

  // Width of each content edge result.
  localparam int EDGE_BITS = 18;

  // Shrink amounts in half-pixel units, tried from the largest down.
  localparam logic [1:0] SHRINK_FULL = 2'd2;
  localparam logic [1:0] SHRINK_NONE = 2'd0;

  // Axis select codes.
  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  // Sequencer states.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PICK  = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_ROUND = 7'b0010000,
    ST_CHECK = 7'b0100000,
    ST_EDGE  = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/tmcr_div.sv -----
// Bit-serial restoring divider with a saturating quotient.
`timescale 1ns / 1ps
`default_nettype none

module tmcr_div #(
  parameter int NW = 31,  // dividend width, one quotient bit per cycle
  parameter int DW = 17,  // divisor width
  parameter int QW = 16   // kept quotient width; larger quotients saturate
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               busy,
  output logic               done,
  output logic [QW-1:0]      quotient
);

  localparam int CW = $clog2(NW);

  logic [NW-1:0] num_sr;
  logic [DW-1:0] dvs;
  logic [DW-1:0] rem;
  logic [QW-1:0] quo;
  logic          ovf;
  logic [CW-1:0] cnt;

  logic [DW:0]   trial;
  logic          take;
  logic [DW:0]   diff;
  logic [DW-1:0] rem_next;

  // One quotient bit per cycle: bring down the next dividend bit and
  // subtract the divisor where it fits.
  always_comb begin
    trial    = {rem, num_sr[NW-1]};
    take     = (trial >= {1'b0, dvs});
    diff     = trial - {1'b0, dvs};
    rem_next = take ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sr <= dividend;
      dvs    <= divisor;
      rem    <= '0;
      quo    <= '0;
      ovf    <= 1'b0;
    end else if (busy) begin
      num_sr <= {num_sr[NW-2:0], 1'b0};
      rem    <= rem_next;
      quo    <= {quo[QW-2:0], take};
      // Any set bit pushed out above the kept width means saturation.
      ovf    <= ovf | quo[QW-1];
    end
  end

  assign quotient = ovf ? '1 : quo;

endmodule

`default_nettype wire

// ----- hdl/tmcr_mul.sv -----
// Bit-serial shift-and-add multiplier, signed by unsigned.
`timescale 1ns / 1ps
`default_nettype none

module tmcr_mul #(
  parameter int AW = 19,  // signed multiplicand width
  parameter int BW = 16   // unsigned multiplier width, one bit per cycle
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [AW-1:0] a,
  input  wire logic        [BW-1:0] b,
  output logic                      busy,
  output logic                      done,
  output logic signed [AW+BW-1:0]   product
);

  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW);

  logic signed [AW-1:0] mcand;
  logic [BW-1:0]        b_sr;
  logic [CW-1:0]        cnt;
  logic signed [PW-1:0] addend;

  assign addend = b_sr[BW-1] ? PW'(mcand) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Multiplier bits enter most significant first, so the running sum
  // doubles before each new partial product is added.
  always_ff @(posedge clk) begin
    if (start) begin
      mcand   <= a;
      b_sr    <= b;
      product <= '0;
    end else if (busy) begin
      b_sr    <= {b_sr[BW-2:0], 1'b0};
      product <= (product <<< 1) + addend;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/texture_matrix_crop_recover.sv -----
// Top level of the texture matrix crop recovery block.
`timescale 1ns / 1ps
`default_nettype none

// Recovers the coded frame size and the content rectangle from the scale and
// translation terms of a texture transform matrix and the displayed size.
// A transaction is accepted on a rising edge with start high and busy low;
// busy then stays high until the result is ready. The result appears on the
// output ports for exactly one cycle with done high, and the receiver cannot
// stall it, so it must be captured in that cycle. The outputs hold their
// values afterwards until the next result. One shared bit-serial divider and
// one bit-serial multiplier do all the work, so the latency is set by them.
// Each axis whose scale magnitude is below one passes through the divide
// (unless its display is too short), multiply and round states in every
// shrink attempt; an axis that is not solved is stepped past, and each
// attempt ends with a check. Up to three attempts are made (shrink 1, 1/2,
// 0). After the last attempt, the EDGE state latches the result and done is
// high in the cycle after that. A zero scale, or two scales of magnitude
// one or more, goes from the accepting edge straight to the EDGE state.
// The worst case has both axes solved in all three attempts.
// A new transaction may be started in the cycle that done is high.
module texture_matrix_crop_recover #(
  parameter int FRAC_BITS  = tmcr_pkg::FRAC_BITS_DEF,
  parameter int SIZE_BITS  = tmcr_pkg::SIZE_BITS_DEF,
  parameter int CODED_BITS = tmcr_pkg::CODED_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  output logic                               done,
  input  wire logic signed [FRAC_BITS+1:0]   scale_x,
  input  wire logic signed [FRAC_BITS+1:0]   scale_y,
  input  wire logic signed [FRAC_BITS+1:0]   shift_x,
  input  wire logic signed [FRAC_BITS+1:0]   shift_y,
  input  wire logic        [SIZE_BITS-1:0]   display_width,
  input  wire logic        [SIZE_BITS-1:0]   display_height,
  output logic             [CODED_BITS-1:0]  coded_width,
  output logic             [CODED_BITS-1:0]  coded_height,
  output logic signed [tmcr_pkg::EDGE_BITS-1:0] edge_left,
  output logic signed [tmcr_pkg::EDGE_BITS-1:0] edge_right,
  output logic signed [tmcr_pkg::EDGE_BITS-1:0] edge_top,
  output logic signed [tmcr_pkg::EDGE_BITS-1:0] edge_bottom
);

  import tmcr_pkg::*;

  // Matrix term width, and translation width after the scale is folded in.
  localparam int W  = FRAC_BITS + 2;
  localparam int TW = W + 1;
  // Divider: dividend is 2*(display - shrink)*2^FRAC_BITS + magnitude.
  localparam int NW = SIZE_BITS + FRAC_BITS + 1;
  localparam int DW = FRAC_BITS + 1;
  // Product of translation and coded size, then twice that less the shrink.
  localparam int PW = TW + CODED_BITS;
  localparam int VW = PW + 2;
  // Rounded offset width.
  localparam int OW = VW - FRAC_BITS - 1;
  // Width in which an edge is summed before it is clamped.
  localparam int SW0 = (OW > SIZE_BITS + 1) ? OW : SIZE_BITS + 1;
  localparam int SW1 = (SW0 > EDGE_BITS) ? SW0 : EDGE_BITS;
  localparam int SW  = SW1 + 1;
  localparam logic signed [SW-1:0] EMAX_W = (SW'(1) <<< (EDGE_BITS - 1)) - SW'(1);
  localparam logic signed [SW-1:0] EMIN_W = -(SW'(1) <<< (EDGE_BITS - 1));

  // Transaction registers.
  state_t                  state;
  logic                    sel;
  logic [1:0]              halves;
  logic signed [TW-1:0]    t_x;
  logic signed [TW-1:0]    t_y;
  logic [FRAC_BITS-1:0]    mag_x;
  logic [FRAC_BITS-1:0]    mag_y;
  logic [SIZE_BITS-1:0]    disp_w;
  logic [SIZE_BITS-1:0]    disp_h;
  logic                    solve_x;
  logic                    solve_y;
  logic                    flip_x;
  logic                    flip_y;
  logic [CODED_BITS-1:0]   cw;
  logic [CODED_BITS-1:0]   ch;
  logic signed [OW-1:0]    offs_x;
  logic signed [OW-1:0]    offs_y;
  logic signed [VW-1:0]    v;

  // Input decode at the accepting edge.
  logic                    accept;
  logic signed [TW-1:0]    sx_ext;
  logic signed [TW-1:0]    sy_ext;
  logic signed [TW-1:0]    abs_x;
  logic signed [TW-1:0]    abs_y;
  logic                    nz_x;
  logic                    nz_y;
  logic                    small_x;
  logic                    small_y;
  logic signed [TW-1:0]    t_x_in;
  logic signed [TW-1:0]    t_y_in;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  always_comb begin
    sx_ext  = TW'(scale_x);
    sy_ext  = TW'(scale_y);
    abs_x   = scale_x[W-1] ? -sx_ext : sx_ext;
    abs_y   = scale_y[W-1] ? -sy_ext : sy_ext;
    nz_x    = (scale_x != '0);
    nz_y    = (scale_y != '0);
    small_x = (abs_x[TW-1:FRAC_BITS] == '0);
    small_y = (abs_y[TW-1:FRAC_BITS] == '0);
    // A scale that is not positive moves the translation by the scale.
    t_x_in  = (nz_x && !scale_x[W-1]) ? TW'(shift_x) : sx_ext + TW'(shift_x);
    t_y_in  = (nz_y && !scale_y[W-1]) ? TW'(shift_y) : sy_ext + TW'(shift_y);
  end

  // Values of the axis being worked on.
  logic                    cur_act;
  logic [FRAC_BITS-1:0]    cur_mag;
  logic [SIZE_BITS-1:0]    cur_disp;
  logic signed [TW-1:0]    cur_t;
  logic                    cur_short;
  logic [SIZE_BITS-1:0]    cur_diff;

  always_comb begin
    cur_act   = (sel == AXIS_Y) ? solve_y : solve_x;
    cur_mag   = (sel == AXIS_Y) ? mag_y : mag_x;
    cur_disp  = (sel == AXIS_Y) ? disp_h : disp_w;
    cur_t     = (sel == AXIS_Y) ? t_y : t_x;
    // A display narrower than twice the shrink gives a coded size of zero.
    cur_short = (cur_disp < SIZE_BITS'(halves));
    cur_diff  = cur_disp - SIZE_BITS'(halves);
  end

  // Shared arithmetic units.
  logic                    div_start;
  logic [NW-1:0]           div_num;
  logic [DW-1:0]           div_dvs;
  logic                    div_busy;
  logic                    div_done;
  logic [CODED_BITS-1:0]   div_q;
  logic                    mul_start;
  logic [CODED_BITS-1:0]   mul_b;
  logic                    mul_busy;
  logic                    mul_done;
  logic signed [PW-1:0]    mul_p;

  assign div_start = (state == ST_PICK) && cur_act && !cur_short;
  // Doubling both sides turns round-half-up into a plain floor division.
  assign div_num   = {cur_diff, 1'b0, cur_mag};
  assign div_dvs   = {cur_mag, 1'b0};
  assign mul_start = ((state == ST_PICK) && cur_act && cur_short) ||
                     ((state == ST_DIV) && div_done);
  assign mul_b     = div_done ? div_q : '0;

  tmcr_div #(
    .NW(NW),
    .DW(DW),
    .QW(CODED_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_num),
    .divisor (div_dvs),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_q)
  );

  tmcr_mul #(
    .AW(TW),
    .BW(CODED_BITS)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (cur_t),
    .b      (mul_b),
    .busy   (mul_busy),
    .done   (mul_done),
    .product(mul_p)
  );

  // Offset before rounding: 2*t*coded - shrink, all in units of 2^-FRAC_BITS.
  logic signed [VW-1:0]    shrink_term;
  logic signed [VW-1:0]    v_next;
  logic signed [VW-1:0]    rnd;
  logic signed [OW-1:0]    offs_next;

  always_comb begin
    shrink_term = VW'({halves, {FRAC_BITS{1'b0}}});
    v_next      = (VW'(mul_p) <<< 1) - shrink_term;
    // Half away from zero: add one half, less one ulp for negative values,
    // then take the floor by dropping the fraction.
    rnd         = v + (VW'(1) <<< FRAC_BITS) - VW'(v[VW-1]);
    offs_next   = rnd[VW-1:FRAC_BITS+1];
  end

  // Edge clamping to the signed edge range.
  function automatic logic signed [EDGE_BITS-1:0] clamp_edge(
    input logic signed [SW-1:0] val
  );
    logic signed [EDGE_BITS-1:0] res;
    if (val > EMAX_W) begin
      res = EMAX_W[EDGE_BITS-1:0];
    end else if (val < EMIN_W) begin
      res = EMIN_W[EDGE_BITS-1:0];
    end else begin
      res = val[EDGE_BITS-1:0];
    end
    return res;
  endfunction

  logic signed [EDGE_BITS-1:0] e_l;
  logic signed [EDGE_BITS-1:0] e_r;
  logic signed [EDGE_BITS-1:0] e_t;
  logic signed [EDGE_BITS-1:0] e_b;

  always_comb begin
    e_l = clamp_edge(SW'(offs_x));
    e_r = clamp_edge(SW'(offs_x) + $signed(SW'({1'b0, disp_w})));
    e_t = clamp_edge(SW'(offs_y));
    e_b = clamp_edge(SW'(offs_y) + $signed(SW'({1'b0, disp_h})));
  end

  // Sequencer. Each attempt walks the x axis and then the y axis; an axis
  // that is not being solved keeps its display size and a zero offset.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (nz_x && nz_y && (small_x || small_y)) begin
              state <= ST_PICK;
            end else begin
              state <= ST_EDGE;
            end
          end
        end
        ST_PICK: begin
          if (!cur_act) begin
            if (sel == AXIS_Y) begin
              state <= ST_CHECK;
            end
          end else if (cur_short) begin
            state <= ST_MUL;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          if (sel == AXIS_Y) begin
            state <= ST_CHECK;
          end else begin
            state <= ST_PICK;
          end
        end
        ST_CHECK: begin
          if ((!offs_x[OW-1] && !offs_y[OW-1]) || (halves == SHRINK_NONE)) begin
            state <= ST_EDGE;
          end else begin
            state <= ST_PICK;
          end
        end
        ST_EDGE: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Working data of the transaction.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          sel     <= AXIS_X;
          halves  <= SHRINK_FULL;
          t_x     <= t_x_in;
          t_y     <= t_y_in;
          mag_x   <= abs_x[FRAC_BITS-1:0];
          mag_y   <= abs_y[FRAC_BITS-1:0];
          disp_w  <= display_width;
          disp_h  <= display_height;
          solve_x <= nz_x && nz_y && small_x;
          solve_y <= nz_x && nz_y && small_y;
          flip_x  <= scale_x[W-1];
          flip_y  <= nz_y && !scale_y[W-1];
          // The default coded size is the display size, saturated.
          cw      <= (CODED_BITS'(SIZE_BITS'('1)) == '1 &&
                      (SIZE_BITS > CODED_BITS) &&
                      ((display_width >> CODED_BITS) != '0)) ? '1
                     : CODED_BITS'(display_width);
          ch      <= (CODED_BITS'(SIZE_BITS'('1)) == '1 &&
                      (SIZE_BITS > CODED_BITS) &&
                      ((display_height >> CODED_BITS) != '0)) ? '1
                     : CODED_BITS'(display_height);
          offs_x  <= '0;
          offs_y  <= '0;
        end
      end
      ST_PICK: begin
        if (!cur_act) begin
          sel <= AXIS_Y;
        end else if (cur_short) begin
          if (sel == AXIS_Y) begin
            ch <= '0;
          end else begin
            cw <= '0;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (sel == AXIS_Y) begin
            ch <= div_q;
          end else begin
            cw <= div_q;
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          v <= v_next;
        end
      end
      ST_ROUND: begin
        if (sel == AXIS_Y) begin
          offs_y <= offs_next;
        end else begin
          offs_x <= offs_next;
          sel    <= AXIS_Y;
        end
      end
      ST_CHECK: begin
        if (!((!offs_x[OW-1] && !offs_y[OW-1]) || (halves == SHRINK_NONE))) begin
          halves <= halves - 2'd1;
          sel    <= AXIS_X;
        end
      end
      ST_EDGE: begin
        coded_width  <= cw;
        coded_height <= ch;
        // A negative x scale mirrors the picture, so left and right trade;
        // a positive y scale does the same for top and bottom.
        edge_left    <= flip_x ? e_r : e_l;
        edge_right   <= flip_x ? e_l : e_r;
        edge_top     <= flip_y ? e_b : e_t;
        edge_bottom  <= flip_y ? e_t : e_b;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted transaction did not raise busy");

  a_div_running: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_busy || div_done))
    else $error("waiting on an idle divider");

  a_mul_running: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (mul_busy || mul_done))
    else $error("waiting on an idle multiplier");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(div_busy && mul_busy))
    else $error("divider and multiplier active together");
`endif

endmodule

`default_nettype wire
